FILE: rtl/core/sfrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrd_pkg
// shared types and constants of the skip/fill run-length frame decoder
// ----------------------------------------------------------------------------
package sfrd_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] OP_END  = 8'd0;
    localparam logic [7:0] OP_ONE  = 8'd1;
    localparam logic [7:0] OP_TWO  = 8'd2;
    localparam logic [7:0] OP_CNT8 = 8'd3;

    typedef enum logic [5:0] {
        PH_OP    = 6'b000001,
        PH_COLOR = 6'b000010,
        PH_CNT8  = 6'b000100,
        PH_CNTLO = 6'b001000,
        PH_CNTHI = 6'b010000,
        PH_DONE  = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        CLS_ONE   = 2'd0,
        CLS_TWO   = 2'd1,
        CLS_CNT8  = 2'd2,
        CLS_CNT16 = 2'd3
    } op_class_t;

    typedef struct packed {
        logic        clr;
        logic        eof;
        logic [15:0] len;
        logic [7:0]  color;
    } cmd_t;

endpackage

FILE: rtl/core/sfrd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrd_if
// byte stream and run descriptor channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface sfrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       frame_begin;

    modport source (output valid, output stream_byte, output frame_begin, input ready);
    modport sink   (input valid, input stream_byte, input frame_begin, output ready);
endinterface

interface sfrd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] run_start;
    logic [15:0] run_length;
    logic [7:0]  run_color;
    logic        run_skip;
    logic        frame_end;

    modport source (output valid, output run_start, output run_length, output run_color,
                    output run_skip, output frame_end, input ready);
    modport sink   (input valid, input run_start, input run_length, input run_color,
                    input run_skip, input frame_end, output ready);
endinterface

FILE: rtl/core/sfrd_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrd_cmd_queue
// small register queue carrying run commands from the parser to the emitter
// ----------------------------------------------------------------------------
module sfrd_cmd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty)) else $error("queue both full and empty");
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> !empty) else $error("queue empty after push");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

endmodule

FILE: rtl/core/sfrd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrd_parser
// front end: accepts stream bytes, tracks opcode, count and color phases
// ----------------------------------------------------------------------------
module sfrd_parser (
    input  logic            clk,
    input  logic            rst_n,
    sfrd_in_if.sink         stream,
    input  logic            q_full,
    output logic            push,
    output sfrd_pkg::cmd_t  cmd
);

    import sfrd_pkg::*;

    phase_t      phase_reg, phase_next;
    op_class_t   cls_reg, cls_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        clr_pend_reg, clr_pend_next;

    phase_t      phase_eff;
    op_class_t   cls_eff;
    logic [15:0] cnt_eff;
    logic        accept;
    logic [7:0]  b;

    assign stream.ready = !q_full;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.stream_byte;

    always_comb
    begin
        phase_eff = stream.frame_begin ? PH_OP    : phase_reg;
        cls_eff   = stream.frame_begin ? CLS_ONE  : cls_reg;
        cnt_eff   = stream.frame_begin ? 16'd0    : cnt_reg;

        phase_next    = phase_reg;
        cls_next      = cls_reg;
        cnt_next      = cnt_reg;
        clr_pend_next = clr_pend_reg;
        push          = 1'b0;
        cmd.clr       = clr_pend_reg || stream.frame_begin;
        cmd.eof       = 1'b0;
        cmd.len       = 16'd0;
        cmd.color     = 8'd0;

        if (accept)
        begin
            phase_next    = phase_eff;
            cls_next      = cls_eff;
            cnt_next      = cnt_eff;
            clr_pend_next = clr_pend_reg || stream.frame_begin;
            case (phase_eff)
                PH_COLOR:
                begin
                    push      = 1'b1;
                    cmd.color = b;
                    case (cls_eff)
                        CLS_ONE: cmd.len = 16'd1;
                        CLS_TWO: cmd.len = 16'd2;
                        default: cmd.len = cnt_eff;
                    endcase
                    phase_next = PH_OP;
                end
                PH_CNT8:
                begin
                    cnt_next   = {8'd0, b};
                    phase_next = PH_COLOR;
                end
                PH_CNTLO:
                begin
                    cnt_next   = {8'd0, b};
                    phase_next = PH_CNTHI;
                end
                PH_CNTHI:
                begin
                    cnt_next   = {b, cnt_eff[7:0]};
                    phase_next = PH_COLOR;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    cnt_next = 16'd0;
                    case (b)
                        OP_END:
                        begin
                            push       = 1'b1;
                            cmd.eof    = 1'b1;
                            phase_next = PH_DONE;
                        end
                        OP_ONE:
                        begin
                            cls_next   = CLS_ONE;
                            phase_next = PH_COLOR;
                        end
                        OP_TWO:
                        begin
                            cls_next   = CLS_TWO;
                            phase_next = PH_COLOR;
                        end
                        OP_CNT8:
                        begin
                            cls_next   = CLS_CNT8;
                            phase_next = PH_CNT8;
                        end
                        default:
                        begin
                            cls_next   = CLS_CNT16;
                            phase_next = PH_CNTLO;
                        end
                    endcase
                end
            endcase
            if (push)
            begin
                clr_pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_OP;
            cls_reg      <= CLS_ONE;
            cnt_reg      <= 16'd0;
            clr_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cls_reg      <= cls_next;
            cnt_reg      <= cnt_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full) else $error("push into full queue");
    a_eof_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        push && cmd.eof |=> phase_reg == PH_DONE) else $error("end opcode not latched");
    a_hi_to_color: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !stream.frame_begin && phase_reg == PH_CNTHI |=> phase_reg == PH_COLOR)
        else $error("high count byte not followed by color phase");

endmodule

FILE: rtl/core/sfrd_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrd_emitter
// back end: holds pixel position, turns commands into run descriptor beats
// ----------------------------------------------------------------------------
module sfrd_emitter #(
    parameter int POS_BITS = sfrd_pkg::POS_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  sfrd_pkg::cmd_t  cmd,
    output logic            pop,
    sfrd_out_if.source      runs
);

    import sfrd_pkg::*;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] start;
    logic                valid_reg;
    logic [15:0]         start_reg;
    logic [15:0]         len_reg;
    logic [7:0]          color_reg;
    logic                skip_reg;
    logic                eof_reg;

    assign pop      = !q_empty && (!valid_reg || runs.ready);
    assign start    = cmd.clr ? '0 : pos_reg;
    assign pos_next = start + POS_BITS'(cmd.len);

    assign runs.valid      = valid_reg;
    assign runs.run_start  = start_reg;
    assign runs.run_length = len_reg;
    assign runs.run_color  = color_reg;
    assign runs.run_skip   = skip_reg;
    assign runs.frame_end  = eof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
                pos_reg   <= pos_next;
            end
            else if (runs.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            start_reg <= 16'(start);
            len_reg   <= cmd.eof ? 16'd0 : cmd.len;
            color_reg <= cmd.eof ? 8'd0 : cmd.color;
            skip_reg  <= !cmd.eof && (cmd.color == 8'd0);
            eof_reg   <= cmd.eof;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty) else $error("pop from empty queue");
    a_eof_clean: assert property (@(posedge clk) disable iff (!rst_n)
        runs.valid && runs.frame_end |-> runs.run_length == 16'd0 && !runs.run_skip)
        else $error("end-of-frame beat carries a run");
    a_clr_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        pop && cmd.clr |=> runs.run_start == 16'd0) else $error("frame start not at zero");

endmodule

FILE: rtl/core/skip_fill_rle_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skip_fill_rle_frame_decoder
// run-length frame decoder with skip runs, one stream byte per beat
// ----------------------------------------------------------------------------
// Takes one compressed byte per cycle on the stream channel and gives one run
// descriptor beat per color byte and one end-of-frame beat per end opcode.
// A parser tracks opcode, count and color phases and pushes run commands into
// a two-entry queue; an emitter keeps the pixel position (POS_BITS wide,
// wrapping) and drives a registered output. A result goes through the queue
// and then the output register after its color byte is taken. Stream ready
// only drops when the queue is full, which happens when the output side stalls.
module skip_fill_rle_frame_decoder #(
    parameter int POS_BITS = sfrd_pkg::POS_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sfrd_in_if.sink     stream,
    sfrd_out_if.source  runs
);

    import sfrd_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    sfrd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .q_full (q_full),
        .push   (push),
        .cmd    (push_cmd)
    );

    sfrd_cmd_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_cmd),
        .pop   (pop),
        .rdata (head_cmd),
        .full  (q_full),
        .empty (q_empty)
    );

    sfrd_emitter #(
        .POS_BITS (POS_BITS)
    ) u_emitter (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .cmd     (head_cmd),
        .pop     (pop),
        .runs    (runs)
    );

endmodule

FILE: verif/sfrd_run_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrd_run_checker
// watches the stream and run channels of the frame decoder, predicts every
// run descriptor and end-of-frame beat from the accepted stream bytes and
// compares each accepted result beat field by field in order
// ----------------------------------------------------------------------------
module sfrd_run_checker #(
    parameter int POS_BITS = sfrd_pkg::POS_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  stream_byte,
    input  logic        frame_begin,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] run_start,
    input  logic [15:0] run_length,
    input  logic [7:0]  run_color,
    input  logic        run_skip,
    input  logic        frame_end,
    output int          fail_count,
    output int          runs_outstanding,
    output int          beats_in,
    output int          runs_seen,
    output int          skips_seen,
    output int          ends_seen
);

    import sfrd_pkg::*;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] len;
        logic [7:0]  color;
        logic        skip;
        logic        eof;
    } run_desc_t;

    run_desc_t              expected_runs[$];
    phase_t                 phase;
    op_class_t              cls;
    logic [15:0]            count_acc;
    logic [POS_BITS-1:0]    position;

    task automatic decode_stream_byte(input logic [7:0] b, input logic fb);
        run_desc_t   d;
        logic [15:0] len;
        logic [31:0] pos_wide;
        if (fb)
        begin
            phase     = PH_OP;
            cls       = CLS_ONE;
            count_acc = '0;
            position  = '0;
        end
        pos_wide = 32'(position);
        case (phase)
            PH_COLOR:
            begin
                case (cls)
                    CLS_ONE: len = 16'd1;
                    CLS_TWO: len = 16'd2;
                    default: len = count_acc;
                endcase
                d.start = pos_wide[15:0];
                d.len   = len;
                d.color = b;
                d.skip  = (b == 8'd0);
                d.eof   = 1'b0;
                expected_runs.push_back(d);
                position = POS_BITS'(position + len);
                phase    = PH_OP;
            end
            PH_CNT8:
            begin
                count_acc = {8'd0, b};
                phase     = PH_COLOR;
            end
            PH_CNTLO:
            begin
                count_acc = {8'd0, b};
                phase     = PH_CNTHI;
            end
            PH_CNTHI:
            begin
                count_acc = {b, count_acc[7:0]};
                phase     = PH_COLOR;
            end
            PH_DONE:
            begin
            end
            default:
            begin
                if (b == OP_END)
                begin
                    d.start = pos_wide[15:0];
                    d.len   = '0;
                    d.color = '0;
                    d.skip  = 1'b0;
                    d.eof   = 1'b1;
                    expected_runs.push_back(d);
                    phase = PH_DONE;
                end
                else
                begin
                    if (b == OP_ONE)
                    begin
                        cls   = CLS_ONE;
                        phase = PH_COLOR;
                    end
                    else if (b == OP_TWO)
                    begin
                        cls   = CLS_TWO;
                        phase = PH_COLOR;
                    end
                    else if (b == OP_CNT8)
                    begin
                        cls   = CLS_CNT8;
                        phase = PH_CNT8;
                    end
                    else
                    begin
                        cls   = CLS_CNT16;
                        phase = PH_CNTLO;
                    end
                    count_acc = '0;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        run_desc_t d;
        run_desc_t got;
        if (!rst_n)
        begin
            phase      = PH_OP;
            cls        = CLS_ONE;
            count_acc  = '0;
            position   = '0;
            expected_runs.delete();
            fail_count = 0;
            beats_in   = 0;
            runs_seen  = 0;
            skips_seen = 0;
            ends_seen  = 0;
            runs_outstanding = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                beats_in = beats_in + 1;
                decode_stream_byte(stream_byte, frame_begin);
            end
            if (out_valid && out_ready)
            begin
                got = '{run_start, run_length, run_color, run_skip, frame_end};
                if (expected_runs.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected result beat: start %h len %h color %h %s %b %s %b",
                                 run_start, run_length, run_color,
                                 "skip", run_skip, "end", frame_end);
                end
                else
                begin
                    d = expected_runs.pop_front();
                    if (got.eof)
                        ends_seen = ends_seen + 1;
                    else
                        runs_seen = runs_seen + 1;
                    if (got.skip)
                        skips_seen = skips_seen + 1;
                    if (got.start !== d.start || got.len !== d.len || got.color !== d.color ||
                        got.skip !== d.skip || got.eof !== d.eof)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch: expected start %h len %h color %h skip %b end %b",
                                     d.start, d.len, d.color, d.skip, d.eof);
                            $display("          got      start %h len %h color %h skip %b end %b",
                                     got.start, got.len, got.color, got.skip, got.eof);
                        end
                    end
                end
            end
            runs_outstanding = expected_runs.size();
        end
    end

endmodule

FILE: verif/tb_skip_fill_rle_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_skip_fill_rle_frame_decoder
// drives the frame decoder with directed and random compressed frames, with
// random gaps on the stream side and random stalls on the run side; the
// checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_skip_fill_rle_frame_decoder;
    import sfrd_pkg::*;

    localparam int          NUM_ITEMS     = 2000;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam logic [7:0]  OP_CNT16_MIN  = 8'd4;
    localparam logic [7:0]  OP_CNT16_MAX  = 8'd255;

    logic clk;
    logic rst_n;
    int   cycles;
    int   items_sent;
    int   quiet_left;
    int   fail_count;
    int   runs_outstanding;
    int   beats_in;
    int   runs_seen;
    int   skips_seen;
    int   ends_seen;

    sfrd_in_if  in_ch ();
    sfrd_out_if out_ch ();

    skip_fill_rle_frame_decoder #(
        .POS_BITS (POS_BITS_DEF)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(in_ch),
        .runs  (out_ch)
    );

    sfrd_run_checker #(
        .POS_BITS (POS_BITS_DEF)
    ) u_run_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_ch.valid),
        .in_ready         (in_ch.ready),
        .stream_byte      (in_ch.stream_byte),
        .frame_begin      (in_ch.frame_begin),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .run_start        (out_ch.run_start),
        .run_length       (out_ch.run_length),
        .run_color        (out_ch.run_color),
        .run_skip         (out_ch.run_skip),
        .frame_end        (out_ch.frame_end),
        .fail_count       (fail_count),
        .runs_outstanding (runs_outstanding),
        .beats_in         (beats_in),
        .runs_seen        (runs_seen),
        .skips_seen       (skips_seen),
        .ends_seen        (ends_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycles, runs_outstanding);
                $display("tb_skip_fill_rle_frame_decoder failed");
                $finish;
            end
        end
    end

    // mostly short gaps, a few long ones, and some stretches with none
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left = quiet_left - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // run side stalls
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                n = $urandom_range(100, 400);
            else
                n = $urandom_range(1, 20);
            repeat (n) @(negedge clk);
            n = pick_gap();
            if (n < 1)
                n = 1;
            out_ch.ready <= 1'b0;
            repeat (n) @(negedge clk);
        end
    end

    // called and returns at a falling edge
    task automatic send_beat(input logic [7:0] b, input logic fb, input bit counted);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.stream_byte <= 8'($urandom);
            in_ch.frame_begin <= 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.stream_byte <= b;
        in_ch.frame_begin <= fb;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        if (counted)
            items_sent = items_sent + 1;
    endtask

    task automatic send_command(input logic fb);
        logic [7:0] op;
        logic [7:0] color;
        case ($urandom_range(0, 3))
            0: op = OP_ONE;
            1: op = OP_TWO;
            2: op = OP_CNT8;
            default: op = 8'($urandom_range(OP_CNT16_MIN, OP_CNT16_MAX));
        endcase
        send_beat(op, fb, 1'b1);
        if (op == OP_CNT8)
            send_beat(8'($urandom), 1'b0, 1'b1);
        else if (op >= OP_CNT16_MIN)
        begin
            send_beat(8'($urandom), 1'b0, 1'b1);
            send_beat(8'($urandom), 1'b0, 1'b1);
        end
        color = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        send_beat(color, 1'b0, 1'b1);
    endtask

    initial
    begin
        int n;
        int r;
        items_sent        = 0;
        quiet_left        = 0;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.stream_byte = 8'd0;
        in_ch.frame_begin = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single pixel skip, two pixel fill, zero and full 8-bit counts
        send_beat(OP_ONE, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(OP_TWO, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(OP_CNT8, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h01, 1'b0, 1'b1);
        send_beat(OP_CNT8, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        // 16-bit counts at both extremes, the largest wraps the position
        send_beat(OP_CNT16_MIN, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h80, 1'b0, 1'b1);
        send_beat(OP_CNT16_MAX, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(8'h55, 1'b0, 1'b1);
        send_beat(OP_ONE, 1'b0, 1'b1);
        send_beat(8'h7F, 1'b0, 1'b1);
        // end of frame, then bytes that must be ignored
        send_beat(OP_END, 1'b0, 1'b1);
        send_beat(OP_ONE, 1'b0, 1'b0);
        send_beat(8'h02, 1'b0, 1'b0);
        // end opcode as the first byte of a frame
        send_beat(OP_END, 1'b1, 1'b1);
        // new frame while a count is half assembled
        send_beat(8'h04, 1'b1, 1'b1);
        send_beat(8'h34, 1'b0, 1'b1);
        send_beat(OP_TWO, 1'b1, 1'b1);
        send_beat(8'hAA, 1'b0, 1'b1);

        while (items_sent < NUM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send_command(i == 0);
                if ($urandom_range(0, 9) != 0)
                begin
                    send_beat(OP_END, 1'b0, 1'b1);
                    repeat ($urandom_range(0, 2))
                        send_beat(8'($urandom), 1'b0, 1'b0);
                end
            end
            else if (r < 90)
            begin
                // truncated command: opcode at a frame begin and one more byte, no color byte
                send_beat(8'($urandom_range(OP_CNT8, OP_CNT16_MAX)), 1'b1, 1'b1);
                send_beat(8'($urandom), 1'b0, 1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(8'($urandom), $urandom_range(0, 7) == 0, 1'b1);
            end
        end
        in_ch.valid <= 1'b0;

        while (runs_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d stream beats in %0d cycles with random gaps and stalls",
                 beats_in, cycles);
        $display("checked %0d run descriptors (%0d skips) and %0d end-of-frame beats",
                 runs_seen, skips_seen, ends_seen);
        if (fail_count == 0 && runs_outstanding == 0)
            $display("tb_skip_fill_rle_frame_decoder passed");
        else
            $display("tb_skip_fill_rle_frame_decoder failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sfrd_pkg.sv
rtl/core/sfrd_if.sv
rtl/core/sfrd_cmd_queue.sv
rtl/core/sfrd_parser.sv
rtl/core/sfrd_emitter.sv
rtl/core/skip_fill_rle_frame_decoder.sv
verif/sfrd_run_checker.sv
verif/tb_skip_fill_rle_frame_decoder.sv
